@@ hdl/pbd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbd_pkg
// Shared types and constants for the pulse beat detector.
// ----------------------------------------------------------------------------
package pbd_pkg;

  // detector phases
  localparam logic [2:0] PH_INIT   = 3'd0;
  localparam logic [2:0] PH_WAIT   = 3'd1;
  localparam logic [2:0] PH_FOLLOW = 3'd2;
  localparam logic [2:0] PH_MAYBE  = 3'd3;
  localparam logic [2:0] PH_MASK   = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_MIN_THR   = 3'd0;
  localparam logic [2:0] REG_MAX_THR   = 3'd1;
  localparam logic [2:0] REG_STEP_RES  = 3'd2;
  localparam logic [2:0] REG_INIT_HOLD = 3'd3;
  localparam logic [2:0] REG_MASK_HOLD = 3'd4;
  localparam logic [2:0] REG_INV_DELAY = 3'd5;
  localparam logic [2:0] REG_ALPHA     = 3'd6;
  localparam logic [2:0] REG_DECAY     = 3'd7;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register reset values
  localparam logic [14:0] RST_MIN_THR   = 15'd320;
  localparam logic [14:0] RST_MAX_THR   = 15'd12800;
  localparam logic [14:0] RST_STEP_RES  = 15'd480;
  localparam logic [15:0] RST_INIT_HOLD = 16'd2000;
  localparam logic [15:0] RST_MASK_HOLD = 16'd200;
  localparam logic [15:0] RST_INV_DELAY = 16'd2000;
  localparam logic [8:0]  RST_ALPHA     = 9'd26;
  localparam logic [8:0]  RST_DECAY     = 9'd251;

  // 60000 ms/min in Q16.8 period to Q9.7 bpm: 60000 * 256 * 128
  localparam logic [30:0] RATE_NUM = 31'd1966080000;
  localparam logic [15:0] RATE_MAX = 16'hFFFF;
  localparam logic [8:0]  Q8_ONE   = 9'd256;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic start_rate;
    logic apply_dec;
    logic apply_rate;
    logic load_out;
  } pbd_cmd_t;

  typedef struct packed {
    logic dec_div;
    logic rate_div;
    logic avg_zero;
    logic div_done;
    logic out_free;
  } pbd_stat_t;

endpackage

@@ hdl/pbd_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbd_in_if
// Sample channel: signed sample and millisecond timestamp.
// ----------------------------------------------------------------------------
interface pbd_in_if #(parameter int SW = 16);
  logic          valid;
  logic          ready;
  logic [SW-1:0] sample_value;
  logic [31:0]   time_ms;

  modport source (output valid, output sample_value, output time_ms, input ready);
  modport sink   (input valid, input sample_value, input time_ms, output ready);
endinterface
`default_nettype wire

@@ hdl/pbd_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbd_out_if
// Result channel: beat flag and rate in Q9.7 bpm.
// ----------------------------------------------------------------------------
interface pbd_out_if;
  logic        valid;
  logic        ready;
  logic        beat_found;
  logic [15:0] rate_bpm;

  modport source (output valid, output beat_found, output rate_bpm, input ready);
  modport sink   (input valid, input beat_found, input rate_bpm, output ready);
endinterface
`default_nettype wire

@@ hdl/pbd_cfg_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbd_cfg_if
// Register write channel: index and data.
// ----------------------------------------------------------------------------
interface pbd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/pbd_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pbd_div #(
  parameter int NW = 34,
  parameter int DW = 24
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quot
);
  localparam int CW = $clog2(NW);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[NW-1]};
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CW'(NW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DW'(trial - {1'b0, den_r});
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DW-1:0];
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
endmodule
`default_nettype wire

@@ hdl/pbd_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbd_dp
// Detector datapath: registers, phase update, threshold decay and rate.
// ----------------------------------------------------------------------------
module pbd_dp
  import pbd_pkg::*;
#(
  parameter int SAMPLE_WIDTH     = 16,
  parameter int FALLOFF_Q8       = 77,
  parameter int SAMPLE_PERIOD_MS = 10
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [SAMPLE_WIDTH-1:0] in_sample,
  input  wire logic [31:0]    in_time,
  pbd_out_if.source           out_chan,
  pbd_cfg_if.sink             cfg_chan,
  input  wire pbd_cmd_t       cmd,
  output pbd_stat_t           st
);
  localparam int EW   = (SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16;
  localparam int KVAL = (256 - FALLOFF_Q8) * SAMPLE_PERIOD_MS;
  localparam int KW   = (KVAL > 0) ? $clog2(KVAL + 1) : 1;
  localparam int NUMW = 15 + KW;
  localparam int NW   = (NUMW > 31) ? NUMW : 31;
  localparam logic [KW-1:0] KCONST = KW'(KVAL);
  localparam logic signed [EW-1:0] SMAX = EW'(32767);
  localparam logic signed [EW-1:0] SMIN = -SMAX - 1;

  // configuration
  logic [14:0] min_thr_r, max_thr_r, step_r;
  logic [15:0] init_hold_r, mask_hold_r, inv_delay_r;
  logic [8:0]  alpha_r, decay_r;

  // detector state
  logic [2:0]         phase_r, phase_x;
  logic [15:0]        thr_r, thr_x;
  logic [23:0]        avg_r, avg_x;
  logic signed [15:0] peak_r, peak_x;
  logic [31:0]        lbt_r, lbt_x;
  logic               seen_r, seen_x;
  logic               beat_r, beat_x;
  logic [15:0]        rate_r, rate_x;

  // item and output registers
  logic signed [15:0] s_r;
  logic [31:0]        now_r;
  logic               out_valid_r;
  logic               out_beat_r;
  logic [15:0]        out_rate_r;

  logic signed [EW-1:0] sx;
  logic signed [15:0]   s_sat;
  logic [31:0]          el;
  logic [15:0]          trk, thr1, geo, geo_cl, dec_cl;
  logic                 s_gt, peak_pos, avg_nz, clr, dec_go, rate_go;
  logic [8:0]           dq, aq;
  logic [24:0]          geo_p;
  logic [23:0]          d_iv;
  logic signed [24:0]   d_diff;
  logic signed [34:0]   a_prod;
  logic signed [35:0]   avg_sum;
  logic [23:0]          avg_new;
  logic [NUMW-1:0]      dec_num;
  logic                 div_start, div_done;
  logic [NW-1:0]        div_num, quot;
  logic signed [NW+1:0] dec_diff;

  // sign extension and saturation of the incoming sample
  always_comb begin
    sx = EW'($signed(in_sample));
    if (sx > SMAX)      s_sat = 16'sh7FFF;
    else if (sx < SMIN) s_sat = -16'sh8000;
    else                s_sat = sx[15:0];
  end

  assign el       = now_r - lbt_r;
  assign s_gt     = $signed({s_r[15], s_r}) > $signed({1'b0, thr_r});
  assign trk      = ($signed(s_r) < $signed({1'b0, max_thr_r})) ? s_r : {1'b0, max_thr_r};
  assign peak_pos = (peak_r > 16'sd0);
  assign avg_nz   = (avg_r != '0);
  assign thr1     = (phase_r == PH_WAIT && s_gt) ? trk : thr_r;
  assign dq       = (decay_r > Q8_ONE) ? Q8_ONE : decay_r;
  assign aq       = (alpha_r > Q8_ONE) ? Q8_ONE : alpha_r;
  assign geo_p    = thr1 * dq;
  assign geo      = geo_p[23:8];
  assign geo_cl   = (geo < {1'b0, min_thr_r}) ? {1'b0, min_thr_r} : geo;

  // period average: (256*avg + a*(d - avg) + 128) >> 8
  assign d_iv    = (el[31:16] != '0) ? 24'hFFFFFF : {el[15:0], 8'h00};
  assign d_diff  = $signed({1'b0, d_iv}) - $signed({1'b0, avg_r});
  assign a_prod  = $signed({1'b0, aq}) * d_diff;
  assign avg_sum = $signed({4'b0, avg_r, 8'h00}) + 36'(a_prod) + 36'sd128;
  assign avg_new = avg_sum[31:8];

  assign dec_num = NUMW'(peak_r[14:0]) * NUMW'(KCONST);

  always_comb begin
    phase_x = phase_r;
    thr_x   = thr_r;
    avg_x   = avg_r;
    peak_x  = peak_r;
    lbt_x   = lbt_r;
    seen_x  = seen_r;
    beat_x  = 1'b0;
    rate_x  = rate_r;
    clr     = 1'b0;
    dec_go  = 1'b0;
    rate_go = 1'b0;
    unique case (phase_r)
      PH_WAIT: begin
        if (s_gt) phase_x = PH_FOLLOW;
        clr = (el > {16'h0, inv_delay_r});
        if (clr) begin
          avg_x  = '0;
          peak_x = '0;
          rate_x = '0;
        end
        dec_go = !clr && peak_pos && avg_nz;
        thr_x  = dec_go ? thr1 : geo_cl;
      end
      PH_FOLLOW: begin
        if ($signed(s_r) < $signed({1'b0, thr_r})) phase_x = PH_MAYBE;
        else                                       thr_x   = trk;
      end
      PH_MAYBE: begin
        if ($signed({{2{s_r[15]}}, s_r}) + $signed({3'b0, step_r})
            < $signed({2'b0, thr_r})) begin
          beat_x  = 1'b1;
          peak_x  = s_r;
          phase_x = PH_MASK;
          lbt_x   = now_r;
          seen_x  = 1'b1;
          if (seen_r) begin
            avg_x   = avg_new;
            rate_go = 1'b1;
          end
        end else begin
          phase_x = PH_FOLLOW;
        end
      end
      PH_MASK: begin
        if (el > {16'h0, mask_hold_r}) phase_x = PH_WAIT;
        dec_go = peak_pos && avg_nz;
        thr_x  = dec_go ? thr1 : geo_cl;
      end
      default: begin
        phase_x = (now_r > {16'h0, init_hold_r}) ? PH_WAIT : PH_INIT;
      end
    endcase
  end

  // shared divider: threshold falloff step or rate
  assign div_start = (cmd.exec && dec_go) || (cmd.start_rate && avg_nz);
  assign div_num   = cmd.exec ? NW'(dec_num) : NW'(RATE_NUM);

  pbd_div #(.NW(NW), .DW(24)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (avg_r),
    .done  (div_done),
    .quot  (quot)
  );

  assign dec_diff = $signed({2'b0, NW'(thr_r)}) - $signed({2'b0, quot});
  assign dec_cl   = (dec_diff < $signed((NW+2)'(min_thr_r))) ? {1'b0, min_thr_r}
                                                              : dec_diff[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_thr_r   <= RST_MIN_THR;
      max_thr_r   <= RST_MAX_THR;
      step_r      <= RST_STEP_RES;
      init_hold_r <= RST_INIT_HOLD;
      mask_hold_r <= RST_MASK_HOLD;
      inv_delay_r <= RST_INV_DELAY;
      alpha_r     <= RST_ALPHA;
      decay_r     <= RST_DECAY;
      phase_r     <= PH_INIT;
      thr_r       <= {1'b0, RST_MIN_THR};
      avg_r       <= '0;
      peak_r      <= '0;
      lbt_r       <= '0;
      seen_r      <= 1'b0;
      beat_r      <= 1'b0;
      rate_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_chan.valid) begin
        unique case (cfg_chan.index)
          REG_MIN_THR:   min_thr_r   <= cfg_chan.data[14:0];
          REG_MAX_THR:   max_thr_r   <= cfg_chan.data[14:0];
          REG_STEP_RES:  step_r      <= cfg_chan.data[14:0];
          REG_INIT_HOLD: init_hold_r <= cfg_chan.data;
          REG_MASK_HOLD: mask_hold_r <= cfg_chan.data;
          REG_INV_DELAY: inv_delay_r <= cfg_chan.data;
          REG_ALPHA:     alpha_r     <= cfg_chan.data[8:0];
          REG_DECAY:     decay_r     <= cfg_chan.data[8:0];
          default:       ;
        endcase
      end
      if (cmd.exec) begin
        phase_r <= phase_x;
        thr_r   <= thr_x;
        avg_r   <= avg_x;
        peak_r  <= peak_x;
        lbt_r   <= lbt_x;
        seen_r  <= seen_x;
        beat_r  <= beat_x;
        rate_r  <= rate_x;
      end
      if (cmd.start_rate && !avg_nz) rate_r <= '0;
      if (cmd.apply_dec) thr_r <= dec_cl;
      if (cmd.apply_rate) rate_r <= (quot > NW'(RATE_MAX)) ? RATE_MAX : quot[15:0];
      if (cmd.load_out)                       out_valid_r <= 1'b1;
      else if (out_chan.ready)                out_valid_r <= 1'b0;
    end
    if (cmd.load_item) begin
      s_r   <= s_sat;
      now_r <= in_time;
    end
    if (cmd.load_out) begin
      out_beat_r <= beat_r;
      out_rate_r <= rate_r;
    end
  end

  assign cfg_chan.ready      = 1'b1;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.beat_found = out_beat_r;
  assign out_chan.rate_bpm   = out_rate_r;

  assign st.dec_div  = dec_go;
  assign st.rate_div = rate_go;
  assign st.avg_zero = !avg_nz;
  assign st.div_done = div_done;
  assign st.out_free = !out_valid_r || out_chan.ready;

  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_INIT || phase_r == PH_WAIT || phase_r == PH_FOLLOW ||
    phase_r == PH_MAYBE || phase_r == PH_MASK)
    else $error("detector phase left its legal set");
  a_thr_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    thr_r[15] == 1'b0)
    else $error("threshold out of range");
  a_rate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply_rate |-> avg_nz)
    else $error("rate division with zero period");
endmodule
`default_nettype wire

@@ hdl/pbd_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbd_ctrl
// Sequencer for one item: load, update, optional division, output.
// ----------------------------------------------------------------------------
module pbd_ctrl
  import pbd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire pbd_stat_t st,
  output pbd_cmd_t       cmd
);
  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_EXEC = 3'd1;
  localparam logic [2:0] C_DEC  = 3'd2;
  localparam logic [2:0] C_AVG  = 3'd3;
  localparam logic [2:0] C_RATE = 3'd4;
  localparam logic [2:0] C_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      C_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
        if (in_valid) state_nxt = C_EXEC;
      end
      C_EXEC: begin
        cmd.exec = 1'b1;
        if (st.dec_div)       state_nxt = C_DEC;
        else if (st.rate_div) state_nxt = C_AVG;
        else                  state_nxt = C_OUT;
      end
      C_DEC: begin
        cmd.apply_dec = st.div_done;
        if (st.div_done) state_nxt = C_OUT;
      end
      C_AVG: begin
        // period was updated in C_EXEC, rate follows from it
        cmd.start_rate = 1'b1;
        state_nxt = st.avg_zero ? C_OUT : C_RATE;
      end
      C_RATE: begin
        cmd.apply_rate = st.div_done;
        if (st.div_done) state_nxt = C_OUT;
      end
      C_OUT: begin
        cmd.load_out = st.out_free;
        if (st.out_free) state_nxt = C_IDLE;
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= C_IDLE;
    else        state_r <= state_nxt;
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    st.div_done |-> (state_r == C_DEC || state_r == C_RATE))
    else $error("divider finished outside a wait state");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> st.out_free)
    else $error("result loaded over a pending one");
  a_exec_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_item |=> cmd.exec)
    else $error("accepted item not processed");
endmodule
`default_nettype wire

@@ hdl/pulse_beat_detector_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pulse_beat_detector_core
// Adaptive-threshold heartbeat detector for AC photoplethysmogram samples.
// ----------------------------------------------------------------------------
// One item is processed at a time. A sample that needs no division is
// updated in C_EXEC and its result loaded into the output register in C_OUT,
// once that register is free. A decaying sample with a known period and a
// positive last peak, or a beat that updates the period, runs the shared
// restoring divider. The divider makes one quotient bit per cycle. The next
// item is accepted in the cycle after the result is loaded, even if it has
// not been taken yet. Configuration writes are always accepted.
module pulse_beat_detector_core
  import pbd_pkg::*;
#(
  parameter int SAMPLE_WIDTH     = 16,
  parameter int FALLOFF_Q8       = 77,
  parameter int SAMPLE_PERIOD_MS = 10
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pbd_in_if.sink    in_chan,
  pbd_out_if.source out_chan,
  pbd_cfg_if.sink   cfg_chan
);
  pbd_cmd_t  cmd;
  pbd_stat_t st;
  logic      in_rdy;

  assign in_chan.ready = in_rdy;

  pbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_rdy),
    .st       (st),
    .cmd      (cmd)
  );

  pbd_dp #(
    .SAMPLE_WIDTH     (SAMPLE_WIDTH),
    .FALLOFF_Q8       (FALLOFF_Q8),
    .SAMPLE_PERIOD_MS (SAMPLE_PERIOD_MS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_sample (in_chan.sample_value),
    .in_time   (in_chan.time_ms),
    .out_chan  (out_chan),
    .cfg_chan  (cfg_chan),
    .cmd       (cmd),
    .st        (st)
  );
endmodule
`default_nettype wire

@@ tb/pulse_beat_detector_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_beat_detector_core_tb
// Drives synthetic pulse waveforms, noise and timestamp jumps into the beat
// detector under several register settings. Each item's beat flag and rate
// are predicted here and compared in order with what the block returns.
// ----------------------------------------------------------------------------
module pulse_beat_detector_core_tb;
  import pbd_pkg::*;

  localparam int FALLOFF = 77;
  localparam int PERIOD_MS = 10;

  typedef struct {
    logic signed [15:0] sample;
    logic [31:0]        stamp;
  } sample_t;

  typedef struct {
    bit          beat;
    logic [15:0] rate;
  } beat_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pbd_in_if #(.SW(16)) in_chan();
  pbd_out_if out_chan();
  pbd_cfg_if cfg_chan();

  pulse_beat_detector_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_chan(in_chan), .out_chan(out_chan), .cfg_chan(cfg_chan)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sample_t      pending_samples[$];
  beat_report_t expected_reports[$];
  int           mismatches = 0;
  bit           idle_in = 1'b0;
  bit           idle_out = 1'b0;

  // register shadows
  longint min_thr, max_thr, step_res;
  logic [31:0] init_hold, mask_hold, inv_delay;
  int unsigned alpha_w, decay_w;

  // detector state
  logic [2:0]  ph;
  longint      thr;
  logic [23:0] avg_per;
  longint      peak;
  logic [31:0] last_beat_t;
  bit          beat_seen;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  function automatic longint clip_to_max(longint s);
    return (s < max_thr) ? s : max_thr;
  endfunction

  function automatic void lower_thr();
    int unsigned dk;
    if (peak > 0 && avg_per != 0) begin
      thr = thr - peak * (256 - FALLOFF) * PERIOD_MS / longint'(avg_per);
    end else begin
      dk = (decay_w > 256) ? 256 : decay_w;
      thr = (thr * dk) >>> 8;
    end
    if (thr < min_thr) thr = min_thr;
  endfunction

  function automatic beat_report_t detect_beat(logic signed [15:0] raw, logic [31:0] now);
    beat_report_t rep;
    longint s;
    logic [31:0] dt;
    longint unsigned d, a, q;
    s = raw;
    dt = now - last_beat_t;
    rep.beat = 1'b0;
    case (ph)
      PH_WAIT: begin
        if (s > thr) begin
          thr = clip_to_max(s);
          ph = PH_FOLLOW;
        end
        if (dt > inv_delay) begin
          avg_per = '0;
          peak = 0;
        end
        lower_thr();
      end
      PH_FOLLOW: begin
        if (s < thr) ph = PH_MAYBE;
        else thr = clip_to_max(s);
      end
      PH_MAYBE: begin
        if (s + step_res < thr) begin
          rep.beat = 1'b1;
          peak = s;
          ph = PH_MASK;
          if (beat_seen) begin
            d = longint'(dt) << 8;
            if (d > 64'hFFFFFF) d = 64'hFFFFFF;
            a = (alpha_w > 256) ? 256 : alpha_w;
            avg_per = 24'((a * d + (256 - a) * avg_per + 128) >> 8);
          end
          last_beat_t = now;
          beat_seen = 1'b1;
        end else begin
          ph = PH_FOLLOW;
        end
      end
      PH_MASK: begin
        if (dt > mask_hold) ph = PH_WAIT;
        lower_thr();
      end
      default: begin
        ph = (now > init_hold) ? PH_WAIT : PH_INIT;
      end
    endcase
    if (avg_per == 0) begin
      rep.rate = '0;
    end else begin
      q = RATE_NUM / avg_per;
      rep.rate = (q > RATE_MAX) ? RATE_MAX : q[15:0];
    end
    return rep;
  endfunction

  // sample driver
  int in_gap = 0;
  always @(posedge clk) begin
    logic next_valid;
    if (rst_n) begin
      next_valid = in_chan.valid;
      if (in_chan.valid && in_chan.ready) begin
        expected_reports.push_back(detect_beat(in_chan.sample_value, in_chan.time_ms));
        next_valid = 1'b0;
        in_gap = idle_in ? pick_gap() : 0;
      end
      if (!next_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_samples.size() > 0) begin
          in_chan.sample_value <= pending_samples[0].sample;
          in_chan.time_ms <= pending_samples[0].stamp;
          void'(pending_samples.pop_front());
          next_valid = 1'b1;
        end
      end
      in_chan.valid <= next_valid;
    end
  end

  // result monitor
  int out_gap = 0;
  always @(posedge clk) begin
    beat_report_t want;
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item: beat %0d rate %0d",
                                         out_chan.beat_found, out_chan.rate_bpm);
        end else begin
          want = expected_reports.pop_front();
          if (out_chan.beat_found !== want.beat || out_chan.rate_bpm !== want.rate) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: beat exp %0d got %0d, rate exp %0d got %0d",
                       want.beat, out_chan.beat_found, want.rate, out_chan.rate_bpm);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_chan.ready <= 1'b0;
      end else if (idle_out && $urandom_range(0, 3) == 0) begin
        out_gap = pick_gap();
        out_chan.ready <= (out_gap == 0);
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data <= val;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    case (idx)
      REG_MIN_THR:   min_thr = val[14:0];
      REG_MAX_THR:   max_thr = val[14:0];
      REG_STEP_RES:  step_res = val[14:0];
      REG_INIT_HOLD: init_hold = val;
      REG_MASK_HOLD: mask_hold = val;
      REG_INV_DELAY: inv_delay = val;
      REG_ALPHA:     alpha_w = val[8:0];
      REG_DECAY:     decay_w = val[8:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(int mn, int mx, int st, int ih, int mh, int iv, int al, int dc);
    write_reg(REG_MIN_THR, 16'(mn));
    write_reg(REG_MAX_THR, 16'(mx));
    write_reg(REG_STEP_RES, 16'(st));
    write_reg(REG_INIT_HOLD, 16'(ih));
    write_reg(REG_MASK_HOLD, 16'(mh));
    write_reg(REG_INV_DELAY, 16'(iv));
    write_reg(REG_ALPHA, 16'(al));
    write_reg(REG_DECAY, 16'(dc));
    cfg_chan.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending_samples.size() > 0 || in_chan.valid || expected_reports.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic push_sample(logic signed [15:0] s, logic [31:0] t);
    sample_t it;
    it.sample = s;
    it.stamp = t;
    pending_samples.push_back(it);
  endtask

  // synthetic pulse train: ramp up, sharp drop, trough, with noise and time jumps
  task automatic push_pulses(int count, inout logic [31:0] t);
    int beat_len, pos, amp, rise, v;
    beat_len = $urandom_range(30, 150);
    amp = $urandom_range(500, 30000);
    pos = 0;
    for (int k = 0; k < count; k++) begin
      rise = beat_len / 3;
      if (pos < rise) v = amp * pos / rise;
      else if (pos == rise) v = amp;
      else v = -amp / 2 + $urandom_range(0, amp / 8);
      v += $urandom_range(0, 64) - 32;
      if ($urandom_range(0, 19) == 0) v = $urandom_range(0, 65535) - 32768;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      push_sample(16'(v), t);
      case ($urandom_range(0, 199))
        0: t = $urandom;
        1, 2: t += $urandom_range(2500, 70000);
        default: t += $urandom_range(8, 12);
      endcase
      pos++;
      if (pos >= beat_len) begin
        pos = 0;
        if ($urandom_range(0, 3) == 0) begin
          beat_len = $urandom_range(30, 150);
          amp = $urandom_range(500, 30000);
        end
      end
    end
  endtask

  initial begin
    logic [31:0] t;
    min_thr = RST_MIN_THR; max_thr = RST_MAX_THR; step_res = RST_STEP_RES;
    init_hold = RST_INIT_HOLD; mask_hold = RST_MASK_HOLD; inv_delay = RST_INV_DELAY;
    alpha_w = RST_ALPHA; decay_w = RST_DECAY;
    ph = PH_INIT; thr = RST_MIN_THR; avg_per = '0; peak = 0;
    last_beat_t = '0; beat_seen = 1'b0;
    in_chan.valid = 1'b0; in_chan.sample_value = '0; in_chan.time_ms = '0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0; cfg_chan.index = '0; cfg_chan.data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: init holdoff edge, extreme samples, first beat, masking, timestamp extremes
    push_sample(16'sd0, 32'd0);
    push_sample(16'sd32767, 32'd2000);
    push_sample(16'sd0, 32'd2001);
    push_sample(16'sd32767, 32'd2010);
    push_sample(16'sd32767, 32'd2020);
    push_sample(16'sd1000, 32'd2030);
    push_sample(-16'sd32768, 32'd2040);
    push_sample(16'sd0, 32'd2100);
    push_sample(16'sd0, 32'd2300);
    push_sample(16'sd20000, 32'd2900);
    push_sample(16'sd5000, 32'd2910);
    push_sample(-16'sd32768, 32'd3000);
    push_sample(16'sd0, 32'd3300);
    push_sample(16'sd0, 32'd3310);
    push_sample(16'sd0, 32'hFFFF_FFFF);
    push_sample(16'sd1, 32'd5);
    // sender holds off here until every result is back
    drain();
    t = 32'd3400;
    idle_in = 1'b1; idle_out = 1'b1;
    push_pulses(300, t);
    drain();

    idle_in = 1'b0; idle_out = 1'b0;
    set_regs(0, 32767, 0, 0, 0, 0, 256, 0);
    t = 32'd0;
    push_pulses(200, t);
    drain();

    idle_in = 1'b1; idle_out = 1'b1;
    set_regs(32767, 0, 32767, 65535, 65535, 65535, 511, 511);
    t = 32'hFFFF_F000;
    push_pulses(150, t);
    drain();

    for (int p = 0; p < 4; p++) begin
      idle_in = ($urandom_range(0, 1) == 1); idle_out = ($urandom_range(0, 1) == 1);
      set_regs($urandom_range(0, 2000), $urandom_range(5000, 32767),
               $urandom_range(0, 3000), $urandom_range(0, 3000),
               $urandom_range(100, 400), $urandom_range(1000, 65535),
               $urandom_range(0, 300), $urandom_range(200, 300));
      t = (p == 0) ? 32'hFFFF_FF00 : $urandom;
      push_pulses(250, t);
      drain();
    end

    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ files.f @@
hdl/pbd_pkg.sv
hdl/pbd_in_if.sv
hdl/pbd_out_if.sv
hdl/pbd_cfg_if.sv
hdl/pbd_div.sv
hdl/pbd_dp.sv
hdl/pbd_ctrl.sv
hdl/pulse_beat_detector_core.sv
tb/pulse_beat_detector_core_tb.sv
